FILE: hw/rtl/sda_pkg.sv
// ----------------------------------------------------------------------------
// sda_pkg: shared types and constants for the signed distance and angle block
// Widths of the square root and CORDIC rows, stage positions and the
// arctangent table in degrees with 20 fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sda_pkg;

	localparam int COORD_BITS    = 16;
	localparam int CORDIC_STAGES = 16;

	localparam int DIST_W    = 22;
	localparam int ANGLE_W   = 16;
	localparam int DIST_MAX  = 2097151;
	localparam int ANGLE_MAX = 23040;

	// CORDIC row
	localparam int ATAN_LEN   = 24;
	localparam int ROT_STAGES = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
	localparam int PRE_SHIFT  = 40 - COORD_BITS;
	localparam int CW         = 44;
	localparam int ZW         = 29;
	localparam int SH_W       = 5;
	localparam int Z_DROP     = 12;
	localparam int Z_HALF     = 2048;

	// square root row: radicand is (dx^2 + dy^2) * 256, padded to an even width
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int N_W    = 2 * COORD_BITS + 10;
	localparam int ROOT_W = N_W / 2;
	localparam int REM_W  = ROOT_W + 3;

	// stage positions, stage 1 being the first register after accept
	localparam int SQ_END   = 3 + ROOT_W;
	localparam int ROT_POST = 2 + ROT_STAGES;
	localparam int LAST     = (SQ_END > ROT_POST) ? SQ_END : ROT_POST;
	localparam int LATENCY  = LAST + 1;

	typedef struct packed {
		logic dneg;  // first x beyond second x
		logic aneg;  // second y below first y
		logic zx;    // dx is zero
		logic zy;    // dy is zero
	} sda_flags_t;

	function automatic logic [ZW-1:0] atan_deg(input int idx);
		logic [ZW-1:0] v;
		case (idx)
			0:       v = ZW'(47185920);
			1:       v = ZW'(27855475);
			2:       v = ZW'(14718068);
			3:       v = ZW'(7471121);
			4:       v = ZW'(3750058);
			5:       v = ZW'(1876857);
			6:       v = ZW'(938658);
			7:       v = ZW'(469357);
			8:       v = ZW'(234682);
			9:       v = ZW'(117342);
			10:      v = ZW'(58671);
			11:      v = ZW'(29335);
			12:      v = ZW'(14668);
			13:      v = ZW'(7334);
			14:      v = ZW'(3667);
			15:      v = ZW'(1833);
			16:      v = ZW'(917);
			17:      v = ZW'(458);
			18:      v = ZW'(229);
			19:      v = ZW'(115);
			20:      v = ZW'(57);
			21:      v = ZW'(29);
			22:      v = ZW'(14);
			23:      v = ZW'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/sda_front.sv
// ----------------------------------------------------------------------------
// sda_front: difference, magnitude and squaring front end
// Stage 1 forms |dx|, |dy| and the sign flags, stage 2 squares both,
// stage 3 forms the radicand (dx^2 + dy^2) * 256.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sda_front (
	input  logic                                clk,
	input  logic signed [sda_pkg::COORD_BITS-1:0] first_x,
	input  logic signed [sda_pkg::COORD_BITS-1:0] first_y,
	input  logic signed [sda_pkg::COORD_BITS-1:0] second_x,
	input  logic signed [sda_pkg::COORD_BITS-1:0] second_y,
	output logic        [sda_pkg::COORD_BITS-1:0] adx_s1,
	output logic        [sda_pkg::COORD_BITS-1:0] ady_s1,
	output sda_pkg::sda_flags_t                   flags_s1,
	output logic        [sda_pkg::N_W-1:0]        n_s3
);
	import sda_pkg::*;

	logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
	logic [COORD_BITS-1:0] adx, ady;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;
	logic [SQ_W:0] sum;

	assign dx  = {second_x[COORD_BITS-1], second_x} - {first_x[COORD_BITS-1], first_x};
	assign dy  = {second_y[COORD_BITS-1], second_y} - {first_y[COORD_BITS-1], first_y};
	assign ndx = -dx;
	assign ndy = -dy;
	assign adx = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
	assign ady = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
	assign sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		adx_s1        <= adx;
		ady_s1        <= ady;
		flags_s1.dneg <= dx[COORD_BITS];
		flags_s1.aneg <= dy[COORD_BITS];
		flags_s1.zx   <= (dx == '0);
		flags_s1.zy   <= (dy == '0);
		sqx_s2        <= SQ_W'(adx_s1) * SQ_W'(adx_s1);
		sqy_s2        <= SQ_W'(ady_s1) * SQ_W'(ady_s1);
		n_s3          <= {1'b0, sum, 8'b0};
	end

endmodule

FILE: hw/rtl/sda_rot_cell.sv
// ----------------------------------------------------------------------------
// sda_rot_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-shamt) and accumulates the angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sda_rot_cell (
	input  logic                           clk,
	input  logic        [sda_pkg::SH_W-1:0] shamt,
	input  logic        [sda_pkg::ZW-1:0]   atan_val,
	input  logic signed [sda_pkg::CW-1:0]   x_in,
	input  logic signed [sda_pkg::CW-1:0]   y_in,
	input  logic signed [sda_pkg::ZW-1:0]   z_in,
	output logic signed [sda_pkg::CW-1:0]   x_q,
	output logic signed [sda_pkg::CW-1:0]   y_q,
	output logic signed [sda_pkg::ZW-1:0]   z_q
);
	import sda_pkg::*;

	logic signed [CW-1:0] xs, ys;
	logic signed [ZW-1:0] za;

	assign xs = x_in >>> shamt;
	assign ys = y_in >>> shamt;
	assign za = signed'(atan_val);

	always_ff @(posedge clk) begin
		// y at or above zero: rotate clockwise
		if (!y_in[CW-1]) begin
			x_q <= x_in + ys;
			y_q <= y_in - xs;
			z_q <= z_in + za;
		end else begin
			x_q <= x_in - ys;
			y_q <= y_in + xs;
			z_q <= z_in - za;
		end
	end

endmodule

FILE: hw/rtl/sda_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sda_sqrt_cell: one digit of a restoring square root
// Brings in the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sda_sqrt_cell (
	input  logic                        clk,
	input  logic [sda_pkg::ROOT_W-1:0]  root_in,
	input  logic [sda_pkg::REM_W-1:0]   rem_in,
	input  logic [sda_pkg::N_W-1:0]     n_in,
	output logic [sda_pkg::ROOT_W-1:0]  root_q,
	output logic [sda_pkg::REM_W-1:0]   rem_q,
	output logic [sda_pkg::N_W-1:0]     n_q
);
	import sda_pkg::*;

	logic [REM_W-1:0] rem_sh, trial;
	logic             ge;

	assign rem_sh = {rem_in[REM_W-3:0], n_in[N_W-1:N_W-2]};
	assign trial  = REM_W'({root_in, 2'b01});
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		rem_q  <= ge ? (rem_sh - trial) : rem_sh;
		root_q <= {root_in[ROOT_W-2:0], ge};
		n_q    <= {n_in[N_W-3:0], 2'b00};
	end

endmodule

FILE: hw/rtl/signed_distance_and_angle.sv
// ----------------------------------------------------------------------------
// signed_distance_and_angle: signed distance and bearing between two points
// Square root row for the length, CORDIC vectoring row for the angle.
// ----------------------------------------------------------------------------
// The 21-cell square root row is the longer of the two rows at the
//   default widths, so it sets when done rises after start.
// Throughput: one point pair per cycle; busy stays low.
// The receiver cannot stall: each result shows for one cycle with done high.
// Reset clears the valid line and done; pairs in flight are dropped.
`timescale 1ns / 1ps

module signed_distance_and_angle (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [sda_pkg::COORD_BITS-1:0] first_x,
	input  logic signed [sda_pkg::COORD_BITS-1:0] first_y,
	input  logic signed [sda_pkg::COORD_BITS-1:0] second_x,
	input  logic signed [sda_pkg::COORD_BITS-1:0] second_y,
	output logic                                 done,
	output logic signed [sda_pkg::DIST_W-1:0]     signed_distance,
	output logic signed [sda_pkg::ANGLE_W-1:0]    angle_degrees,
	output logic                                 angle_undefined
);
	import sda_pkg::*;

	localparam int MW      = (ROOT_W + 1 > DIST_W) ? ROOT_W + 1 : DIST_W;
	localparam int SQ_DLY  = LAST - SQ_END;
	localparam int ANG_DLY = LAST - ROT_POST;

	logic [COORD_BITS-1:0] adx_s1, ady_s1;
	sda_flags_t            flags_s1;
	logic [N_W-1:0]        n_s3;

	logic [LAST:1] vld_q;
	sda_flags_t    fl_q [2:LAST];

	assign busy = 1'b0;

	sda_front u_front (
		.clk      (clk),
		.first_x  (first_x),
		.first_y  (first_y),
		.second_x (second_x),
		.second_y (second_y),
		.adx_s1   (adx_s1),
		.ady_s1   (ady_s1),
		.flags_s1 (flags_s1),
		.n_s3     (n_s3)
	);

	// valid and flag line, one tap per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAST-1:1], start};
		end
	end

	always_ff @(posedge clk) begin
		fl_q[2] <= flags_s1;
		for (int k = 3; k <= LAST; k++) begin
			fl_q[k] <= fl_q[k-1];
		end
	end

	// CORDIC row: start from (|dy|, |dx|)
	logic signed [CW-1:0] cx [0:ROT_STAGES];
	logic signed [CW-1:0] cy [0:ROT_STAGES];
	logic signed [ZW-1:0] cz [0:ROT_STAGES];

	assign cx[0] = signed'(CW'({ady_s1, {PRE_SHIFT{1'b0}}}));
	assign cy[0] = signed'(CW'({adx_s1, {PRE_SHIFT{1'b0}}}));
	assign cz[0] = '0;

	for (genvar i = 0; i < ROT_STAGES; i++) begin : g_rot
		sda_rot_cell u_cell (
			.clk      (clk),
			.shamt    (SH_W'(i)),
			.atan_val (atan_deg(i)),
			.x_in     (cx[i]),
			.y_in     (cy[i]),
			.z_in     (cz[i]),
			.x_q      (cx[i+1]),
			.y_q      (cy[i+1]),
			.z_q      (cz[i+1])
		);
	end

	// square root row
	logic [ROOT_W-1:0] sr_root [0:ROOT_W];
	logic [REM_W-1:0]  sr_rem  [0:ROOT_W];
	logic [N_W-1:0]    sr_n    [0:ROOT_W];

	assign sr_root[0] = '0;
	assign sr_rem[0]  = '0;
	assign sr_n[0]    = n_s3;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		sda_sqrt_cell u_cell (
			.clk     (clk),
			.root_in (sr_root[i]),
			.rem_in  (sr_rem[i]),
			.n_in    (sr_n[i]),
			.root_q  (sr_root[i+1]),
			.rem_q   (sr_rem[i+1]),
			.n_q     (sr_n[i+1])
		);
	end

	// angle finish: clamp, round to Q8.8, special cases, sign
	sda_flags_t                  fa;
	logic        [ZW-1:0]        zc, zr_full;
	logic        [ANGLE_W-1:0]   zr, amag;
	logic                        und;
	logic signed [ANGLE_W-1:0]   aval;
	logic        [ANGLE_W:0]     ang_q, ang_l;

	assign fa      = fl_q[ROT_POST-1];
	assign zc      = cz[ROT_STAGES][ZW-1] ? '0 : cz[ROT_STAGES];
	assign zr_full = (zc + ZW'(Z_HALF)) >> Z_DROP;
	assign zr      = (zr_full > ZW'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : zr_full[ANGLE_W-1:0];

	always_comb begin
		und  = 1'b0;
		amag = zr;
		if (fa.zx && fa.zy) begin
			amag = '0;
			und  = 1'b1;
		end else if (fa.zy) begin
			amag = ANGLE_W'(ANGLE_MAX);
		end else if (fa.zx) begin
			amag = '0;
		end
	end

	assign aval = fa.aneg ? -signed'(amag) : signed'(amag);

	always_ff @(posedge clk) begin
		ang_q <= {und, aval};
	end

	// hold each row's result until the other row catches up
	if (ANG_DLY == 0) begin : g_ang_nodly
		assign ang_l = ang_q;
	end else begin : g_ang_dly
		logic [ANGLE_W:0] ang_dq [1:ANG_DLY];
		always_ff @(posedge clk) begin
			ang_dq[1] <= ang_q;
			for (int k = 2; k <= ANG_DLY; k++) begin
				ang_dq[k] <= ang_dq[k-1];
			end
		end
		assign ang_l = ang_dq[ANG_DLY];
	end

	logic [ROOT_W-1:0] root_l;
	logic [REM_W-1:0]  rem_l;

	if (SQ_DLY == 0) begin : g_sq_nodly
		assign root_l = sr_root[ROOT_W];
		assign rem_l  = sr_rem[ROOT_W];
	end else begin : g_sq_dly
		logic [ROOT_W-1:0] root_dq [1:SQ_DLY];
		logic [REM_W-1:0]  rem_dq  [1:SQ_DLY];
		always_ff @(posedge clk) begin
			root_dq[1] <= sr_root[ROOT_W];
			rem_dq[1]  <= sr_rem[ROOT_W];
			for (int k = 2; k <= SQ_DLY; k++) begin
				root_dq[k] <= root_dq[k-1];
				rem_dq[k]  <= rem_dq[k-1];
			end
		end
		assign root_l = root_dq[SQ_DLY];
		assign rem_l  = rem_dq[SQ_DLY];
	end

	// distance finish: round to nearest, saturate, sign
	logic                     rnd;
	logic [MW-1:0]            mag;
	logic [DIST_W-1:0]        dmag;
	logic signed [DIST_W-1:0] dval;

	assign rnd  = (rem_l > REM_W'(root_l));
	assign mag  = MW'(root_l) + MW'(rnd);
	assign dmag = (mag > MW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : mag[DIST_W-1:0];
	assign dval = fl_q[LAST].dneg ? -signed'(dmag) : signed'(dmag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_q[LAST];
		end
	end

	always_ff @(posedge clk) begin
		signed_distance <= dval;
		angle_degrees   <= signed'(ang_l[ANGLE_W-1:0]);
		angle_undefined <= ang_l[ANGLE_W];
	end

endmodule

FILE: hw/rtl/sda_checker.sv
// ----------------------------------------------------------------------------
// sda_checker: port-level checks for signed_distance_and_angle
// Latency of each beat and consistency of the result fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sda_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic signed [sda_pkg::COORD_BITS-1:0] first_x,
	input logic signed [sda_pkg::COORD_BITS-1:0] first_y,
	input logic signed [sda_pkg::COORD_BITS-1:0] second_x,
	input logic signed [sda_pkg::COORD_BITS-1:0] second_y,
	input logic                                 done,
	input logic signed [sda_pkg::DIST_W-1:0]     signed_distance,
	input logic signed [sda_pkg::ANGLE_W-1:0]    angle_degrees,
	input logic                                 angle_undefined
);
	import sda_pkg::*;

	// every accepted beat produces a result with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done)
		else $error("accepted beat did not produce a result on time");

	// no result without a matching accepted beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without an accepted beat");

	// coincident points give zero distance, zero angle and the flag
	a_coincide: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(first_x == second_x && first_y == second_y, LATENCY)
		|-> angle_undefined && angle_degrees == '0 && signed_distance == '0)
		else $error("coincident points not flagged");

	// distinct points have a nonzero distance and an angle in range
	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		done && !angle_undefined
		|-> signed_distance != '0 && angle_degrees <= ANGLE_MAX
			&& angle_degrees >= -ANGLE_MAX)
		else $error("distance or angle out of range for distinct points");

endmodule

bind signed_distance_and_angle sda_checker u_sda_checker (.*);
